// File: design/occ_pkg.sv
// Shared constants, types and relation update functions for the order closure block.
package occ_pkg;

	localparam int VertexCount = 16;
	localparam int VW = $clog2(VertexCount);

	localparam logic [1:0] REL_NONE = 2'd0;
	localparam logic [1:0] REL_LE   = 2'd1;
	localparam logic [1:0] REL_LT   = 2'd2;

	localparam logic [1:0] KIND_ADD_VERTEX = 2'd0;
	localparam logic [1:0] KIND_ADD_CONSTR = 2'd1;
	localparam logic [1:0] KIND_SATURATE   = 2'd2;

	typedef logic [VertexCount-1:0][1:0] row_t;
	typedef logic [VW-1:0] vtx_t;

	function automatic logic [1:0] occ_put(logic [1:0] cur, logic [1:0] rel, logic self_edge);
		logic [1:0] res;
		res = cur;
		if (rel == REL_LE) begin
			if (!self_edge && cur == REL_NONE) res = REL_LE;
		end else if (rel == REL_LT) begin
			res = REL_LT;
		end
		return res;
	endfunction

	function automatic row_t occ_compose(row_t ri, row_t rk, logic [1:0] a, vtx_t i);
		row_t res;
		logic [1:0] rel;
		res = ri;
		for (int j = 0; j < VertexCount; j++) begin
			if (a != REL_NONE && rk[j] != REL_NONE) begin
				rel = (a == REL_LE && rk[j] == REL_LE) ? REL_LE : REL_LT;
				res[j] = occ_put(ri[j], rel, vtx_t'(j) == i);
			end
		end
		return res;
	endfunction

endpackage

// File: design/occ_row_ram.sv
// Relation matrix row memory: one write port, two registered read ports.
module occ_row_ram (
	input  logic              clk,
	input  logic              we,
	input  occ_pkg::vtx_t     waddr,
	input  occ_pkg::row_t     wdata,
	input  occ_pkg::vtx_t     raddr_a,
	input  occ_pkg::vtx_t     raddr_b,
	output occ_pkg::row_t     rdata_a,
	output occ_pkg::row_t     rdata_b
);

	occ_pkg::row_t mem [occ_pkg::VertexCount];

	always_ff @(posedge clk) begin
		if (we) mem[waddr] <= wdata;
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: design/order_constraint_closure.sv
// Order constraint closure: present map, row memory of relations and control sequencer.
// Add vertex or rejected constraint: straight to the result state; add constraint:
// one row read-modify-write (read state, then write state). Saturate: a read state and a
// write state per (row, pivot) pair, 256 pairs per sweep of the 16x16 matrix,
// repeated until a sweep changes nothing. One item at a time. After reset a pass
// clears the 16 matrix rows; no item is accepted until it finishes.
module order_constraint_closure (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // first_vertex[3:0], second_vertex[7:4], strict[8]
	input  logic [1:0]  s_tuser,  // kind[1:0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata   // status[0], consistent[1]
);

	typedef enum logic [2:0] {
		ST_CLR, ST_IDLE, ST_ADD_RD, ST_ADD_WR, ST_SAT_RD, ST_SAT_WR, ST_FIN
	} state_t;

	state_t state_q;
	logic [occ_pkg::VertexCount-1:0] present_q;
	occ_pkg::vtx_t v1_q, v2_q, i_q, k_q, clr_q;
	logic strict_q, status_q, cons_q, changed_q, bad_q;

	logic we;
	occ_pkg::vtx_t waddr, raddr_a, raddr_b;
	occ_pkg::row_t wdata, rdata_a, rdata_b, new_row;
	logic [1:0] add_cur, add_rel;
	logic k_last, sweep_end, diag_lt;

	occ_row_ram u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr_a(raddr_a), .raddr_b(raddr_b), .rdata_a(rdata_a), .rdata_b(rdata_b)
	);

	occ_pkg::vtx_t in_v1, in_v2;
	assign in_v1 = s_tdata[3:0];
	assign in_v2 = s_tdata[7:4];
	assign s_tready = (state_q == ST_IDLE);

	assign k_last = (k_q == occ_pkg::vtx_t'(occ_pkg::VertexCount - 1));
	assign sweep_end = k_last && (i_q == occ_pkg::vtx_t'(occ_pkg::VertexCount - 1));
	assign diag_lt = (rdata_a[i_q] == occ_pkg::REL_LT);

	always_comb begin
		add_cur = rdata_a[v2_q];
		add_rel = strict_q ? occ_pkg::REL_LT : occ_pkg::REL_LE;
		new_row = occ_pkg::occ_compose(rdata_a, rdata_b, rdata_a[k_q], i_q);
		raddr_a = (state_q == ST_ADD_RD) ? v1_q : i_q;
		raddr_b = k_q;
		we = 1'b0;
		waddr = i_q;
		wdata = new_row;
		unique case (state_q)
			ST_CLR: begin
				we = 1'b1;
				waddr = clr_q;
				wdata = '0;
			end
			ST_ADD_WR: begin
				we = 1'b1;
				waddr = v1_q;
				wdata = rdata_a;
				wdata[v2_q] = occ_pkg::occ_put(add_cur, add_rel, v1_q == v2_q);
			end
			ST_SAT_WR: we = (new_row != rdata_a);
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLR;
			present_q <= '0;
			clr_q <= '0;
			m_tvalid <= 1'b0;
			m_tdata <= '0;
			v1_q <= '0;
			v2_q <= '0;
			i_q <= '0;
			k_q <= '0;
			strict_q <= 1'b0;
			status_q <= 1'b0;
			cons_q <= 1'b0;
			changed_q <= 1'b0;
			bad_q <= 1'b0;
		end else begin
			if (m_tvalid && m_tready && state_q != ST_FIN) m_tvalid <= 1'b0;
			unique case (state_q)
				ST_CLR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == occ_pkg::vtx_t'(occ_pkg::VertexCount - 1)) state_q <= ST_IDLE;
				end
				ST_IDLE: begin
					if (s_tvalid) begin
						v1_q <= in_v1;
						v2_q <= in_v2;
						strict_q <= s_tdata[8];
						status_q <= (s_tuser == occ_pkg::KIND_ADD_CONSTR) &&
							!(present_q[in_v1] && present_q[in_v2]);
						cons_q <= 1'b0;
						i_q <= '0;
						k_q <= '0;
						changed_q <= 1'b0;
						bad_q <= 1'b0;
						unique case (s_tuser)
							occ_pkg::KIND_ADD_VERTEX: begin
								present_q[in_v1] <= 1'b1;
								state_q <= ST_FIN;
							end
							occ_pkg::KIND_ADD_CONSTR: begin
								if (present_q[in_v1] && present_q[in_v2]) state_q <= ST_ADD_RD;
								else state_q <= ST_FIN;
							end
							occ_pkg::KIND_SATURATE: state_q <= ST_SAT_RD;
							default: state_q <= ST_FIN;
						endcase
					end
				end
				ST_ADD_RD: state_q <= ST_ADD_WR;
				ST_ADD_WR: state_q <= ST_FIN;
				ST_SAT_RD: state_q <= ST_SAT_WR;
				ST_SAT_WR: begin
					k_q <= k_q + 1'b1;
					if (k_last) i_q <= i_q + 1'b1;
					if (sweep_end) begin
						changed_q <= 1'b0;
						bad_q <= 1'b0;
						if (!(changed_q | we)) begin
							cons_q <= !(bad_q | diag_lt);
							state_q <= ST_FIN;
						end else begin
							state_q <= ST_SAT_RD;
						end
					end else begin
						changed_q <= changed_q | we;
						bad_q <= bad_q | diag_lt;
						state_q <= ST_SAT_RD;
					end
				end
				ST_FIN: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid <= 1'b1;
						m_tdata <= {6'd0, cons_q, status_q};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule
